// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert that a property holds at every rising clock edge outside reset.
`define CHK_HOLDS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assert that a condition is never seen outside reset.
`define CHK_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- hw/rtl/ps2md_pkg.sv -----
// Package: widths, register indexes, event codes, structs and arithmetic helpers.
package ps2md_pkg;

	localparam int POS_W      = 10;
	localparam int OUT_POS_W  = 10;
	localparam int LIM_W      = 10;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;
	localparam int BYTE_W     = 8;
	localparam int KIND_W     = 2;
	localparam int BTN_W      = 5;
	localparam int DELTA_W    = 11;
	localparam int SUM_W      = ((POS_W > DELTA_W) ? POS_W : DELTA_W) + 2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WHEEL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_X = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_Y = 2'd2;

	// Event codes
	localparam logic [KIND_W-1:0] EV_MOVED = 2'd0;
	localparam logic [KIND_W-1:0] EV_DOWN  = 2'd1;
	localparam logic [KIND_W-1:0] EV_UP    = 2'd2;

	// Reset values
	localparam logic [LIM_W-1:0] MAX_X_RESET    = LIM_W'(1023);
	localparam logic [LIM_W-1:0] MAX_Y_RESET    = LIM_W'(767);
	localparam logic [POS_W-1:0] CURSOR_X_RESET = POS_W'(400);
	localparam logic [POS_W-1:0] CURSOR_Y_RESET = POS_W'(300);

	// Byte layout
	localparam int DX_SIGN_BIT = 4;
	localparam int DY_SIGN_BIT = 5;

	localparam logic signed [DELTA_W-1:0] SCALE_LIMIT = DELTA_W'(5);
	localparam logic signed [SUM_W-1:0]   POS_MAX     = SUM_W'((1 << POS_W) - 1);

	typedef struct packed {
		logic             wheel;
		logic [LIM_W-1:0] max_x;
		logic [LIM_W-1:0] max_y;
	} cfg_t;

	typedef struct packed {
		logic              fire;
		logic [BYTE_W-1:0] b0;
		logic [BYTE_W-1:0] b1;
		logic [BYTE_W-1:0] b2;
		logic [BYTE_W-1:0] b3;
	} pkt_t;

	// Triple a delta whose magnitude exceeds the threshold
	function automatic logic signed [DELTA_W-1:0] scale_delta(
		input logic signed [DELTA_W-1:0] d
	);
		if (d > SCALE_LIMIT || d < -SCALE_LIMIT) begin
			return (d <<< 1) + d;
		end
		return d;
	endfunction

	// Move a position and clamp it to 0..limit, limit bounded by the position range
	function automatic logic [POS_W-1:0] move_clamped(
		input logic [POS_W-1:0]          pos,
		input logic signed [DELTA_W-1:0] d,
		input logic [LIM_W-1:0]          limit
	);
		logic signed [SUM_W-1:0] v;
		logic signed [SUM_W-1:0] lim;
		v   = $signed(SUM_W'(pos)) + SUM_W'(d);
		lim = $signed(SUM_W'(limit));
		if (lim > POS_MAX) begin
			lim = POS_MAX;
		end
		if (v < 0) begin
			v = '0;
		end
		if (v > lim) begin
			v = lim;
		end
		return POS_W'(v);
	endfunction

endpackage

// ----- hw/rtl/ps2md_byte_if.sv -----
// Interface: mouse byte channel.
interface ps2md_byte_if;
	import ps2md_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

// ----- hw/rtl/ps2md_event_if.sv -----
// Interface: decoded mouse event channel.
interface ps2md_event_if;
	import ps2md_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [KIND_W-1:0]    event_kind;
	logic [OUT_POS_W-1:0] pos_x;
	logic [OUT_POS_W-1:0] pos_y;
	logic [BTN_W-1:0]     button_bits;
	logic                 last_event;

	modport source (output valid, output event_kind, output pos_x, output pos_y,
		output button_bits, output last_event, input ready);
	modport sink (input valid, input event_kind, input pos_x, input pos_y,
		input button_bits, input last_event, output ready);
endinterface

// ----- hw/rtl/ps2_mouse_packet_decoder_top.sv -----
// Path: a packet's final byte passes the input register and is then loaded into the
// event register, where its first event becomes valid; it waits in the input register
// while the event register is busy. Throughput: one byte per cycle but for such waits;
// the input register and the event register part the two sides, and a packet with a
// move and a button change holds the event register until both its events are taken.
// Reset: asynchronous, active low; cursor to (400, 300), limits 1023 and 767,
// three-byte mode, packet count and button history cleared.
module ps2_mouse_packet_decoder_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ps2md_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ps2md_pkg::CFG_DATA_W-1:0] cfg_wdata,
	ps2md_byte_if.sink                       byte_in,
	ps2md_event_if.source                    event_out
);
	import ps2md_pkg::*;

	cfg_t cfg;
	pkt_t pkt;
	logic pair_free;

	ps2md_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	ps2md_assembler u_asm (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (byte_in.valid),
		.in_byte   (byte_in.data_byte),
		.in_ready  (byte_in.ready),
		.pair_free (pair_free),
		.pkt       (pkt)
	);

	ps2md_event_unit u_evt (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.pkt       (pkt),
		.pair_free (pair_free),
		.event_out (event_out)
	);
endmodule

// ----- hw/rtl/ps2md_cfg_regs.sv -----
// Configuration registers: wheel mode and the cursor clamp limits.
module ps2md_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ps2md_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ps2md_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output ps2md_pkg::cfg_t                cfg
);
	import ps2md_pkg::*;

	cfg_t cfg_q;

	// Write the addressed register, drop unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wheel <= 1'b0;
			cfg_q.max_x <= MAX_X_RESET;
			cfg_q.max_y <= MAX_Y_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WHEEL: cfg_q.wheel <= cfg_wdata[0];
				REG_MAX_X: cfg_q.max_x <= cfg_wdata[LIM_W-1:0];
				REG_MAX_Y: cfg_q.max_y <= cfg_wdata[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

// ----- hw/rtl/ps2md_assembler.sv -----
// Packet assembler: input register, stored packet bytes and byte count.
module ps2md_assembler (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ps2md_pkg::cfg_t              cfg,
	input  logic                         in_valid,
	input  logic [ps2md_pkg::BYTE_W-1:0] in_byte,
	output logic                         in_ready,
	input  logic                         pair_free,
	output ps2md_pkg::pkt_t              pkt
);
	import ps2md_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic [BYTE_W-1:0] pkt_q [3];
	logic [1:0]        count_q;
	logic [1:0]        last_idx;
	logic              completes;
	logic              advance;

	// A byte completes the packet once the count reaches the mode's last index
	assign last_idx  = cfg.wheel ? 2'd3 : 2'd2;
	assign completes = (count_q >= last_idx);
	assign advance   = valid_s1 && (!completes || pair_free);
	assign in_ready  = !valid_s1 || advance;

	// Hold the byte until it can advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	// Store a non-final byte, restart the count on a finished packet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 2'd0;
			pkt_q[0] <= '0;
			pkt_q[1] <= '0;
			pkt_q[2] <= '0;
		end else if (advance) begin
			if (completes) begin
				count_q <= 2'd0;
			end else begin
				count_q <= count_q + 2'd1;
				case (count_q)
					2'd0: pkt_q[0] <= byte_s1;
					2'd1: pkt_q[1] <= byte_s1;
					2'd2: pkt_q[2] <= byte_s1;
					default: ;
				endcase
			end
		end
	end

	// Present the finished packet; in three-byte mode the extra byte is zero
	always_comb begin
		pkt.fire = advance && completes;
		pkt.b0   = pkt_q[0];
		pkt.b1   = pkt_q[1];
		if (cfg.wheel) begin
			pkt.b2 = pkt_q[2];
			pkt.b3 = byte_s1;
		end else begin
			pkt.b2 = (count_q == 2'd2) ? byte_s1 : pkt_q[2];
			pkt.b3 = '0;
		end
	end
endmodule

// ----- hw/rtl/ps2md_event_unit.sv -----
// Event unit: decode deltas and buttons, move the cursor, hold up to two events.
module ps2md_event_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  ps2md_pkg::cfg_t  cfg,
	input  ps2md_pkg::pkt_t  pkt,
	output logic             pair_free,
	ps2md_event_if.source    event_out
);
	import ps2md_pkg::*;

	logic [POS_W-1:0]          cursor_x_q;
	logic [POS_W-1:0]          cursor_y_q;
	logic [BTN_W-1:0]          prev_btn_q;
	logic [1:0]                rem_q;
	logic [KIND_W-1:0]         kind_b_q;
	logic [POS_W-1:0]          pos_x_q;
	logic [POS_W-1:0]          pos_y_q;
	logic [BTN_W-1:0]          btn_q;

	logic [BTN_W-1:0]          btn;
	logic signed [DELTA_W-1:0] dx_raw;
	logic signed [DELTA_W-1:0] dy_raw;
	logic signed [DELTA_W-1:0] dx;
	logic signed [DELTA_W-1:0] dy;
	logic [POS_W-1:0]          new_x;
	logic [POS_W-1:0]          new_y;
	logic                      moved;
	logic                      btn_chg;
	logic [1:0]                n_events;
	logic                      out_fire;

	// Decode buttons and signed deltas; dy is negated
	always_comb begin
		btn    = {pkt.b3[5:4], pkt.b0[2:0]};
		dx_raw = DELTA_W'($signed({pkt.b0[DX_SIGN_BIT], pkt.b1}));
		dy_raw = -DELTA_W'($signed({pkt.b0[DY_SIGN_BIT], pkt.b2}));
		dx     = scale_delta(dx_raw);
		dy     = scale_delta(dy_raw);
		new_x  = move_clamped(cursor_x_q, dx, cfg.max_x);
		new_y  = move_clamped(cursor_y_q, dy, cfg.max_y);
		moved  = (dx_raw != '0) || (dy_raw != '0) || (pkt.b3[3:0] != 4'd0);
		btn_chg  = (btn != prev_btn_q);
		n_events = {1'b0, moved} + {1'b0, btn_chg};
	end

	assign out_fire  = event_out.valid && event_out.ready;
	assign pair_free = (rem_q == 2'd0) || (rem_q == 2'd1 && event_out.ready);

	// Advance the cursor and button history on every finished packet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q <= CURSOR_X_RESET;
			cursor_y_q <= CURSOR_Y_RESET;
			prev_btn_q <= '0;
		end else if (pkt.fire) begin
			cursor_x_q <= new_x;
			cursor_y_q <= new_y;
			prev_btn_q <= btn;
		end
	end

	// Load the event pair, drain one event per output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 2'd0;
		end else if (pkt.fire && n_events != 2'd0) begin
			rem_q <= n_events;
		end else if (out_fire) begin
			rem_q <= rem_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt.fire && n_events != 2'd0) begin
			kind_b_q <= !btn_chg ? EV_MOVED : ((btn != '0) ? EV_DOWN : EV_UP);
			pos_x_q  <= new_x;
			pos_y_q  <= new_y;
			btn_q    <= btn;
		end
	end

	// The first of two events is always the move
	assign event_out.valid       = (rem_q != 2'd0);
	assign event_out.event_kind  = (rem_q == 2'd2) ? EV_MOVED : kind_b_q;
	assign event_out.pos_x       = OUT_POS_W'(pos_x_q);
	assign event_out.pos_y       = OUT_POS_W'(pos_y_q);
	assign event_out.button_bits = btn_q;
	assign event_out.last_event  = (rem_q == 2'd1);
endmodule

// ----- hw/rtl/ps2md_checker.sv -----
// Checker on the top level's event port, attached by bind.
`include "assert_macros.svh"

module ps2md_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [ps2md_pkg::KIND_W-1:0]    event_kind,
	input logic [ps2md_pkg::OUT_POS_W-1:0] pos_x,
	input logic [ps2md_pkg::OUT_POS_W-1:0] pos_y,
	input logic [ps2md_pkg::BTN_W-1:0]     button_bits,
	input logic                            last_event
);
	import ps2md_pkg::*;

	// A stalled event keeps its payload
	`CHK_HOLDS(a_stall_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable({event_kind, pos_x, pos_y, button_bits, last_event}), "stalled event changed")

	// Only a move may precede another event of the same packet
	`CHK_NEVER(a_first_is_move, clk, arst_n, out_valid && !last_event && event_kind != EV_MOVED, "non-final event is not a move")

	// The event after a move that is not final is the packet's button event
	`CHK_HOLDS(a_pair_follow, clk, arst_n, out_valid && out_ready && !last_event |=> out_valid && last_event && event_kind != EV_MOVED, "button event missing after move")

	// Down carries pressed buttons, up carries none
	`CHK_NEVER(a_down_up_bits, clk, arst_n, out_valid && ((event_kind == EV_DOWN && button_bits == '0) || (event_kind == EV_UP && button_bits != '0)), "button event disagrees with buttons")

	// Both events of a packet show the same position and buttons
	`CHK_HOLDS(a_pair_same, clk, arst_n, out_valid && out_ready && !last_event |=> $stable({pos_x, pos_y, button_bits}), "event pair payload differs")
endmodule

bind ps2_mouse_packet_decoder_top ps2md_checker u_ps2md_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (event_out.valid),
	.out_ready   (event_out.ready),
	.event_kind  (event_out.event_kind),
	.pos_x       (event_out.pos_x),
	.pos_y       (event_out.pos_y),
	.button_bits (event_out.button_bits),
	.last_event  (event_out.last_event)
);

// ----- test/ps2md_event_checker.sv -----
// Event checker: predicts decoded mouse events from the accepted bytes and compares them.
module ps2md_event_checker
	import ps2md_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	ps2md_byte_if                 byte_mon,
	ps2md_event_if                event_mon,
	output int                    fail_count,
	output int                    pending,
	output int                    packets_done,
	output int                    events_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BIG_DELTA  = 5;
	localparam int MAX_REPORTS = 100;

	typedef struct packed {
		logic [KIND_W-1:0]    kind;
		logic [OUT_POS_W-1:0] x;
		logic [OUT_POS_W-1:0] y;
		logic [BTN_W-1:0]     buttons;
		logic                 last;
	} mouse_event_t;

	mouse_event_t      expected_events[$];
	logic              wheel_mode;
	logic [LIM_W-1:0]  clamp_x;
	logic [LIM_W-1:0]  clamp_y;
	logic [BYTE_W-1:0] held_bytes [3];
	logic [1:0]        fill_level;
	logic [POS_W-1:0]  pos_x_now;
	logic [POS_W-1:0]  pos_y_now;
	logic [BTN_W-1:0]  button_state;

	// Triple a delta whose size is above the threshold
	function automatic int tripled_if_large(input int d);
		if (d > BIG_DELTA || d < -BIG_DELTA) return d * 3;
		return d;
	endfunction

	// Move the cursor and hold it inside 0..limit
	function automatic logic [POS_W-1:0] clamped_move(input logic [POS_W-1:0] pos,
		input int d, input logic [LIM_W-1:0] limit);
		int v;
		v = int'(pos) + d;
		if (v < 0) v = 0;
		if (v > int'(limit)) v = int'(limit);
		return POS_W'(v);
	endfunction

	task automatic report_mismatch(input string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS) $display("%0t: event %0d: %s", $time, events_seen, msg);
	endtask

	task automatic compare_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want) report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
	endtask

	// Gather bytes; on a complete packet move the cursor and queue its events
	task automatic decode_mouse_byte(input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] b0, b1, b2, b3;
		logic [BTN_W-1:0]  buttons;
		logic [1:0]        final_slot;
		int                dx, dy, dz;
		bit                moved, changed;
		final_slot = wheel_mode ? 2'd3 : 2'd2;
		if (fill_level < final_slot) begin
			held_bytes[fill_level] = b;
			fill_level++;
			return;
		end
		b0 = held_bytes[0];
		b1 = held_bytes[1];
		if (wheel_mode) begin
			b2 = held_bytes[2];
			b3 = b;
		end else if (fill_level == 2'd2) begin
			b2 = b;
			b3 = '0;
		end else begin
			// three bytes were pending when three-byte mode came back: drop this one
			b2 = held_bytes[2];
			b3 = '0;
		end
		fill_level = '0;
		packets_done++;
		buttons = {b3[5:4], b0[2:0]};
		dx = b0[DX_SIGN_BIT] ? int'(b1) - 256 : int'(b1);
		dy = b0[DY_SIGN_BIT] ? 256 - int'(b2) : -int'(b2);
		dz = b3[3] ? int'(b3[2:0]) - 8 : int'(b3[2:0]);
		dx = tripled_if_large(dx);
		dy = tripled_if_large(dy);
		pos_x_now = clamped_move(pos_x_now, dx, clamp_x);
		pos_y_now = clamped_move(pos_y_now, dy, clamp_y);
		moved   = (dx != 0) || (dy != 0) || (dz != 0);
		changed = (buttons != button_state);
		if (moved)
			expected_events.push_back('{EV_MOVED, pos_x_now, pos_y_now, buttons, !changed});
		if (changed)
			expected_events.push_back('{(buttons != '0) ? EV_DOWN : EV_UP,
				pos_x_now, pos_y_now, buttons, 1'b1});
		button_state = buttons;
	endtask

	task automatic check_event();
		mouse_event_t want;
		events_seen++;
		if (expected_events.size() == 0) begin
			report_mismatch($sformatf("kind %0d at (%0d,%0d) arrived with none expected",
				event_mon.event_kind, event_mon.pos_x, event_mon.pos_y));
			return;
		end
		want = expected_events.pop_front();
		compare_field("event_kind", 32'(event_mon.event_kind), 32'(want.kind));
		compare_field("pos_x", 32'(event_mon.pos_x), 32'(want.x));
		compare_field("pos_y", 32'(event_mon.pos_y), 32'(want.y));
		compare_field("button_bits", 32'(event_mon.button_bits), 32'(want.buttons));
		compare_field("last_event", 32'(event_mon.last_event), 32'(want.last));
	endtask

	// Follow register writes, check accepted events, predict from accepted bytes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheel_mode   = 1'b0;
			clamp_x      = MAX_X_RESET;
			clamp_y      = MAX_Y_RESET;
			held_bytes   = '{default: '0};
			fill_level   = '0;
			pos_x_now    = CURSOR_X_RESET;
			pos_y_now    = CURSOR_Y_RESET;
			button_state = '0;
			expected_events.delete();
			pending = 0;
		end else begin
			if (event_mon.valid === 1'b1 && event_mon.ready === 1'b1) check_event();
			if (cfg_we) begin
				case (cfg_index)
					REG_WHEEL: wheel_mode = cfg_wdata[0];
					REG_MAX_X: clamp_x = LIM_W'(cfg_wdata);
					REG_MAX_Y: clamp_y = LIM_W'(cfg_wdata);
					// other indexes change nothing
					default: ;
				endcase
			end
			if (byte_mon.valid === 1'b1 && byte_mon.ready === 1'b1)
				decode_mouse_byte(byte_mon.data_byte);
			pending = expected_events.size();
		end
	end

endmodule

// ----- test/tb_top.sv -----
// Testbench top: clock, reset, mouse byte stimulus, event receiver and verdict.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import ps2md_pkg::*;

	localparam int RESET_CYCLES      = 10;
	localparam int SETTLE_CYCLES     = 8;
	localparam int LONG_STALL        = 400;
	localparam int CYCLE_LIMIT       = 500000;
	localparam int PHASES            = 7;
	localparam int PACKETS_PER_PHASE = 48;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	int fail_count;
	int pending;
	int packets_done;
	int events_seen;
	int bytes_sent     = 0;
	int writes_done    = 0;
	int stall_requests = 0;
	int stalls_served  = 0;
	int cycle_count    = 0;
	bit tx_eager       = 1'b0;
	bit rx_eager       = 1'b0;
	bit wheel_now      = 1'b0;
	logic [2:0] main_buttons = '0;
	logic [1:0] side_buttons = '0;

	// Directed three-byte packets under reset settings
	logic [BYTE_W-1:0] three_byte_cases [18] = '{
		8'h00, 8'h00, 8'h00,   // no movement, no buttons: nothing comes out
		8'h09, 8'h05, 8'h05,   // deltas at the threshold, left down
		8'h18, 8'h00, 8'h00,   // dx of -256 pins x at zero, release
		8'h28, 8'h00, 8'h00,   // dy of +256 pins y at max_y
		8'h0F, 8'hFF, 8'hFF,   // largest dx, dy of -255, three buttons down
		8'h08, 8'h06, 8'h06    // just above the threshold, release
	};
	// Directed four-byte packets with both limits at zero
	logic [BYTE_W-1:0] wheel_cases [8] = '{
		8'h08, 8'h00, 8'h00, 8'h08,   // wheel only, most negative dz
		8'h08, 8'h00, 8'h00, 8'h37    // largest dz, buttons 4 and 5 down
	};

	ps2md_byte_if  byte_ch();
	ps2md_event_if event_ch();

	ps2_mouse_packet_decoder_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.byte_in   (byte_ch),
		.event_out (event_ch)
	);

	ps2md_event_checker u_event_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.byte_mon     (byte_ch),
		.event_mon    (event_ch),
		.fail_count   (fail_count),
		.pending      (pending),
		.packets_done (packets_done),
		.events_seen  (events_seen)
	);

	always #5 clk = ~clk;

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("ps2_mouse_packet_decoder_top verification failed");
			$finish;
		end
	end

	// Mostly no gap, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Small deltas of either sign most of the time, any byte now and then
	function automatic logic [BYTE_W-1:0] delta_byte(input bit negative);
		int r;
		int mag;
		r = $urandom_range(0, 99);
		if (r < 25) mag = 0;
		else if (r < 80) mag = $urandom_range(1, 8);
		else return BYTE_W'($urandom);
		return negative ? BYTE_W'(256 - mag) : BYTE_W'(mag);
	endfunction

	// Receiver: random hold-offs, plus one long stall on request
	initial begin
		int hold;
		event_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_requests != stalls_served) begin
				event_ch.ready <= 1'b0;
				repeat (LONG_STALL - 1) @(negedge clk);
				stalls_served++;
			end else if (rx_eager) begin
				event_ch.ready <= 1'b1;
			end else begin
				hold = pick_gap();
				event_ch.ready <= (hold == 0);
				if (hold > 1) repeat (hold - 1) @(negedge clk);
			end
		end
	end

	// Offer one byte, after a random gap unless tx_eager is set; return on the falling edge after it is taken
	task automatic send_byte(input logic [BYTE_W-1:0] value);
		int gap;
		gap = tx_eager ? 0 : pick_gap();
		if (gap > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_ch.valid     <= 1'b1;
		byte_ch.data_byte <= value;
		do @(posedge clk); while (byte_ch.ready !== 1'b1);
		@(negedge clk);
		bytes_sent++;
	endtask

	// Drop valid and hold until every predicted event has come out
	task automatic wait_for_events();
		byte_ch.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		writes_done++;
	endtask

	// Let the block go idle, then write every register
	task automatic apply_settings(input bit wheel, input int limit_x, input int limit_y);
		logic [CFG_DATA_W-1:0] mode_word;
		wait_for_events();
		repeat (SETTLE_CYCLES) @(negedge clk);
		mode_word    = CFG_DATA_W'($urandom);
		mode_word[0] = wheel;
		write_reg(REG_WHEEL, mode_word);
		write_reg(REG_MAX_X, CFG_DATA_W'(limit_x));
		write_reg(REG_MAX_Y, CFG_DATA_W'(limit_y));
		write_reg(REG_SPARE, CFG_DATA_W'($urandom));
		wheel_now = wheel;
	endtask

	// Mostly well-formed packet with random content; buttons tend to stay put
	task automatic send_random_packet();
		logic [BYTE_W-1:0] head;
		logic [BYTE_W-1:0] extra;
		if ($urandom_range(0, 9) == 0) begin
			head = BYTE_W'($urandom);
		end else begin
			if ($urandom_range(0, 2) == 0) main_buttons = 3'($urandom);
			head = {2'b00, 2'($urandom), 1'b1, main_buttons};
		end
		if ($urandom_range(0, 9) == 0) begin
			extra = BYTE_W'($urandom);
		end else begin
			if ($urandom_range(0, 3) == 0) side_buttons = 2'($urandom);
			extra = {2'($urandom), side_buttons,
				($urandom_range(0, 1) == 0) ? 4'h0 : 4'($urandom)};
		end
		send_byte(head);
		send_byte(delta_byte(head[DX_SIGN_BIT]));
		send_byte(delta_byte(head[DY_SIGN_BIT]));
		if (wheel_now) send_byte(extra);
	endtask

	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = REG_WHEEL;
		cfg_wdata         = '0;
		byte_ch.valid     = 1'b0;
		byte_ch.data_byte = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Directed packets, first under reset settings, then four-byte with zero limits
		foreach (three_byte_cases[i]) send_byte(three_byte_cases[i]);
		apply_settings(1'b1, 0, 0);
		foreach (wheel_cases[i]) send_byte(wheel_cases[i]);

		// Leave three bytes pending, return to three-byte mode: the next byte is dropped
		send_byte(8'h09);
		send_byte(8'h02);
		send_byte(8'h02);
		apply_settings(1'b0, 1023, 1023);
		send_byte(8'hFF);

		// Random phases over a spread of settings
		for (int phase = 0; phase < PHASES; phase++) begin
			// leave a partial packet behind now and then before the change
			repeat ($urandom_range(0, 3)) send_byte(BYTE_W'($urandom));
			case (phase)
				0: apply_settings(1'b1, 1023, 1023);
				1: apply_settings(1'b0, 0, 0);
				2: apply_settings(1'b1, $urandom_range(0, 1023), $urandom_range(0, 1023));
				3: apply_settings(1'b0, 1023, $urandom_range(0, 1023));
				4: apply_settings(1'b1, 0, 1023);
				5: apply_settings(1'b0, $urandom_range(0, 1023), $urandom_range(0, 1023));
				default: apply_settings(1'b1, $urandom_range(0, 1023), $urandom_range(0, 1023));
			endcase
			// back-to-back on both sides in one phase; in another a long receiver stall
			// while the sender keeps pushing
			tx_eager = (phase == 2) || (phase == 4);
			rx_eager = (phase == 2);
			if (phase == 4) stall_requests++;
			for (int k = 0; k < PACKETS_PER_PHASE; k++) begin
				if (phase == 4 && k == 30) tx_eager = 1'b0;
				if (k == PACKETS_PER_PHASE / 2) wait_for_events();
				if ($urandom_range(0, 19) == 0) send_byte(BYTE_W'($urandom));
				else send_random_packet();
			end
		end

		wait_for_events();
		repeat (SETTLE_CYCLES * 4) @(negedge clk);
		$display("Run sent %0d mouse bytes: %0d packets decoded, %0d events checked",
			bytes_sent, packets_done, events_seen);
		$display("Both packet sizes, mode changes mid-packet, limits 0..1023, %0d register writes",
			writes_done);
		if (fail_count == 0) begin
			$display("ps2_mouse_packet_decoder_top verification clean");
		end else begin
			$display("ps2_mouse_packet_decoder_top verification failed");
		end
		$finish;
	end

endmodule
